>>> sv/rubnh_pkg.sv
package rubnh_pkg;

  localparam int unsigned MaxItemsDefault = 4096;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DistW = 48;
  localparam int unsigned IndexW = 12;
  localparam int unsigned DivW = 50;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegOriginX = 3'd0;
  localparam logic [2:0] RegOriginY = 3'd1;
  localparam logic [2:0] RegOriginZ = 3'd2;
  localparam logic [2:0] RegDirX = 3'd3;
  localparam logic [2:0] RegDirY = 3'd4;
  localparam logic [2:0] RegDirZ = 3'd5;
  localparam logic [2:0] RegMaxDist = 3'd6;

  localparam logic [DistW-1:0] LimitReset = 48'd6553600;

  typedef enum logic [3:0] {
    StIdle,
    StDivStart,
    StDivWait,
    StAxisDone,
    StDistMul,
    StDistSq,
    StUpdate,
    StOut
  } state_e;

  // Start, busy and done of the shared divider.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

>>> sv/rubnh_div.sv
// Restoring divider: one quotient bit per cycle, signed result truncated to zero.
module rubnh_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [rubnh_pkg::DivW-1:0] num_i,
  input  logic signed [17:0]              den_i,
  output rubnh_pkg::div_ctl_t             ctl_o,
  output logic signed [rubnh_pkg::DivW:0] quo_o
);
  import rubnh_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] num_q, num_d;
  logic [17:0]     den_q, den_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DivW:0]   trial;

  // One shift and subtract step per cycle.
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[DivW-1]} - {{(DivW-17){1'b0}}, den_q};
    if (start_i) begin
      num_d  = num_i[DivW-1] ? DivW'(-num_i) : DivW'(num_i);
      den_d  = den_i[17] ? 18'(-den_i) : 18'(den_i);
      neg_d  = num_i[DivW-1] ^ den_i[17];
      rem_d  = '0;
      cnt_d  = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivW]) begin
        rem_d = trial[DivW-1:0];
        num_d = {num_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivW-2:0], num_q[DivW-1]};
        num_d = {num_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign quo_o = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};

endmodule

>>> sv/ray_unit_box_nearest_hit_unit.sv
// Nearest-hit picker. A cube word is accepted, then passes an axis-done marker
// state and up to six slab divisions, two per axis. Each division starts the
// shared 50-bit bit-serial divider, waits for its quotient and folds it in.
// An axis with a zero direction skips its two divisions and is checked against
// its slab instead. After that come a multiply and a square for each of the
// three axes for the distance, then the update, so the bit-serial divider sets
// the time. The unit takes no word while busy. A result word appears only
// after a word marked tlast and waits in the output register. The next result
// holds the unit until the previous one is taken. Configure only while idle.
module ray_unit_box_nearest_hit_unit #(
  parameter int unsigned MAX_ITEMS = rubnh_pkg::MaxItemsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: box_x[15:0], box_y[31:16], box_z[47:32]
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: found[0], hit_index[12:1], hit_t[44:13], hit_dist_sq[92:45], zeros
  output logic [95:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import rubnh_pkg::*;

  localparam int unsigned CntW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  logic signed [31:0] org_q [3];
  logic signed [17:0] dir_q [3];
  logic [DistW-1:0]   lim_q;

  logic [DistW-1:0]   best_dist_q, best_dist_d;
  logic [IndexW-1:0]  best_idx_q, best_idx_d;
  logic signed [31:0] best_t_q, best_t_d;
  logic               any_q, any_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  state_e             st_q, st_d;
  logic signed [15:0] box_q [3];
  logic               last_q;
  logic [1:0]         ax_q, ax_d;
  logic               hi_q, hi_d;
  logic signed [31:0] t0_q, t0_d;
  logic signed [31:0] entry_q, entry_d, exit_q, exit_d;
  logic               miss_q, miss_d;
  logic [DistW+2:0]   sum_q, sum_d;
  logic [31:0]        p_q, p_d;
  logic               out_v_q;
  logic [95:0]        out_q;

  logic [2:0]          reg_idx;
  logic                wr_en;
  logic signed [33:0]  lo_v, hi_v, bound;
  logic signed [DivW-1:0] num;
  logic                div_start;
  div_ctl_t            div_ctl;
  logic signed [DivW:0] quo;
  logic signed [31:0]  t_sat, tmin, tmax;
  logic [31:0]         emag;
  logic [17:0]         dmag;
  logic [49:0]         prod;
  logic [63:0]         sq;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= '0;
        dir_q[i] <= '0;
      end
      lim_q <= LimitReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegOriginX: org_q[0] <= pwdata[31:0];
        RegOriginY: org_q[1] <= pwdata[31:0];
        RegOriginZ: org_q[2] <= pwdata[31:0];
        RegDirX:    dir_q[0] <= pwdata[17:0];
        RegDirY:    dir_q[1] <= pwdata[17:0];
        RegDirZ:    dir_q[2] <= pwdata[17:0];
        RegMaxDist: lim_q    <= pwdata[DistW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      RegOriginX: prdata = 64'(unsigned'(org_q[0]));
      RegOriginY: prdata = 64'(unsigned'(org_q[1]));
      RegOriginZ: prdata = 64'(unsigned'(org_q[2]));
      RegDirX:    prdata = 64'(unsigned'(dir_q[0]));
      RegDirY:    prdata = 64'(unsigned'(dir_q[1]));
      RegDirZ:    prdata = 64'(unsigned'(dir_q[2]));
      RegMaxDist: prdata = 64'(lim_q);
      default:    prdata = '0;
    endcase
  end

  // Slab bounds of the current axis.
  assign lo_v  = 34'(box_q[ax_q]) * 34'sd65536 - 34'sd32768 - 34'(org_q[ax_q]);
  assign hi_v  = 34'(box_q[ax_q]) * 34'sd65536 + 34'sd32768 - 34'(org_q[ax_q]);
  assign bound = hi_q ? hi_v : lo_v;
  assign num   = {bound, 16'd0};
  assign div_start = (st_q == StDivStart);

  rubnh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (dir_q[ax_q]),
    .ctl_o  (div_ctl),
    .quo_o  (quo)
  );

  assign t_sat = (quo > 51'sd2147483647) ? 32'sh7fffffff :
                 (quo < -51'sd2147483648) ? 32'sh80000000 : quo[31:0];
  assign tmin = (t0_q < t_sat) ? t0_q : t_sat;
  assign tmax = (t0_q < t_sat) ? t_sat : t0_q;

  // Magnitudes for the distance; the most negative direction gives 2^17.
  assign emag = entry_q[31] ? 32'(-entry_q) : entry_q;
  assign dmag = dir_q[ax_q][17] ? 18'(-dir_q[ax_q]) : 18'(dir_q[ax_q]);
  assign prod = 50'(emag) * 50'(dmag);
  assign sq   = 64'(p_q) * 64'(p_q);

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:     if (s_axis_tvalid && s_axis_tready) st_d = StAxisDone;
      StDivStart: st_d = StDivWait;
      StDivWait:  if (div_ctl.done) st_d = StAxisDone;
      StAxisDone: begin
        if (ax_q == 2'd2 && (hi_q || dir_q[ax_q] == '0 || miss_q)) begin
          st_d = StDistMul;
        end else if (dir_q[ax_d] != '0 && !miss_d) begin
          st_d = StDivStart;
        end
      end
      StDistMul:  st_d = StDistSq;
      StDistSq:   st_d = (ax_q == 2'd2) ? StUpdate : StDistMul;
      StUpdate:   st_d = last_q ? StOut : StIdle;
      StOut:      if (!out_v_q) st_d = StIdle;
      default:    st_d = StIdle;
    endcase
  end

  // Datapath control per state.
  always_comb begin
    ax_d = ax_q; hi_d = hi_q; t0_d = t0_q;
    entry_d = entry_q; exit_d = exit_q; miss_d = miss_q;
    sum_d = sum_q; p_d = p_q;
    best_dist_d = best_dist_q; best_idx_d = best_idx_q;
    best_t_d = best_t_q; any_d = any_q; cnt_d = cnt_q;
    case (st_q)
      StIdle: begin
        ax_d = 2'd0; hi_d = 1'b0; miss_d = 1'b0;
        entry_d = 32'sh80000000; exit_d = 32'sh7fffffff;
        // Marker pass: the axis-done state starting at axis 0 with nothing done.
        hi_d = 1'b1; ax_d = 2'd3;
      end
      // The lower bound's time is kept; the upper one is read from the divider.
      StDivWait: if (div_ctl.done && !hi_q) t0_d = t_sat;
      StAxisDone: begin
        // Close out the axis just finished, then set up the next one.
        if (ax_q != 2'd3) begin
          if (dir_q[ax_q] == '0) begin
            if (lo_v > 0 || hi_v < 0) miss_d = 1'b1;
          end else if (hi_q) begin
            if (tmin > entry_q) entry_d = tmin;
            if (tmax < exit_q) exit_d = tmax;
          end
        end
        if (ax_q != 2'd3 && dir_q[ax_q] != '0 && !hi_q) begin
          hi_d = 1'b1;
        end else begin
          ax_d = ax_q + 2'd1;
          hi_d = 1'b0;
        end
        if (ax_q == 2'd2 && (hi_q || dir_q[ax_q] == '0 || miss_q)) begin
          ax_d = 2'd0; sum_d = '0;
        end
      end
      StDistMul: p_d = (prod[49:48] != 2'b00) ? 32'hffffffff : prod[47:16];
      StDistSq: begin
        sum_d = sum_q + (DistW+3)'(sq[63:16]);
        ax_d  = ax_q + 2'd1;
      end
      StUpdate: begin
        if (!miss_q && entry_q <= exit_q &&
            ((sum_q > (DistW+3)'({DistW{1'b1}})) ? {DistW{1'b1}} : sum_q[DistW-1:0])
            < (any_q ? best_dist_q : lim_q)) begin
          best_dist_d = (sum_q > (DistW+3)'({DistW{1'b1}})) ? {DistW{1'b1}} :
                        sum_q[DistW-1:0];
          best_idx_d = IndexW'(cnt_q);
          best_t_d = entry_q;
          any_d = 1'b1;
        end
        cnt_d = (cnt_q == CntW'(MAX_ITEMS - 1)) ? '0 : cnt_q + 1'b1;
      end
      StOut: if (!out_v_q) begin
        best_dist_d = lim_q; best_idx_d = '0; best_t_d = '0;
        any_d = 1'b0; cnt_d = '0;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (st_q == StIdle);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; ax_q <= '0; hi_q <= 1'b0; miss_q <= 1'b0;
      best_dist_q <= LimitReset; best_idx_q <= '0; best_t_q <= '0;
      any_q <= 1'b0; cnt_q <= '0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; ax_q <= ax_d; hi_q <= hi_d; miss_q <= miss_d;
      best_dist_q <= (st_q == StIdle && !any_q && cnt_q == '0) ? lim_q : best_dist_d;
      best_idx_q <= best_idx_d; best_t_q <= best_t_d;
      any_q <= any_d; cnt_q <= cnt_d;
      if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
      else if (st_q == StOut && !out_v_q) out_v_q <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    t0_q <= t0_d; entry_q <= entry_d; exit_q <= exit_d;
    sum_q <= sum_d; p_q <= p_d;
    if (s_axis_tvalid && s_axis_tready) begin
      box_q[0] <= s_axis_tdata[15:0];
      box_q[1] <= s_axis_tdata[31:16];
      box_q[2] <= s_axis_tdata[47:32];
      last_q   <= s_axis_tlast;
    end
    if (st_q == StOut && !out_v_q) begin
      out_q <= any_q ? {3'b000, best_dist_q, best_t_q, best_idx_q, 1'b1} : '0;
    end
  end

  // A result word is only raised after a scan ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(st_q) == StOut)
    else $error("result raised outside output state");
  // No cube is accepted while the divider is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.busy |-> !s_axis_tready)
    else $error("input accepted while divider busy");
  // A finished result holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

endmodule
